[rtl/pcfp_pkg.sv]
// Shared types and constants for the front-plane polygon clipper.
package pcfp_pkg;

  localparam int COUNT_W     = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // result tuser bit positions
  localparam int TU_VALID = 0;
  localparam int TU_CROSS = 1;
  localparam int TU_DONE  = 2;
  localparam int TUSER_W  = 3;

  typedef enum logic [1:0] {
    OP_VERTEX,
    OP_CROSS,
    OP_DONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     run_last;
  } op_ctl_t;

endpackage

[rtl/pcfp_fifo.sv]
// Small first-in first-out queue of clip operations between front and back.
module pcfp_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  import pcfp_pkg::*;

  logic [W-1:0]        mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign full  = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[rtl/pcfp_front.sv]
// Front part: takes vertices, tracks previous and first vertex, issues clip operations.
module pcfp_front #(
  parameter int CW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CW-1:0]          in_x,
  input  logic [CW-1:0]          in_y,
  input  logic [CW-1:0]          in_z,
  input  logic                   in_last,
  output logic                   push,
  input  logic                   full,
  output pcfp_pkg::op_ctl_t      ctl,
  output logic [CW-1:0]          p_x,
  output logic [CW-1:0]          p_y,
  output logic [CW-1:0]          p_z,
  output logic [CW-1:0]          c_x,
  output logic [CW-1:0]          c_y,
  output logic [CW-1:0]          c_z
);
  import pcfp_pkg::*;

  logic [CW-1:0] prev_x, prev_y, prev_z;
  logic          prev_in;
  logic [CW-1:0] first_x, first_y, first_z;
  logic          first_in;
  logic          awaiting;
  logic [CW-1:0] cur_x, cur_y, cur_z;
  logic [CW-1:0] edge_x, edge_y, edge_z;
  // pending ops: 0 entry crossing, 1 current vertex, 2 closing crossing, 3 done marker
  logic [3:0]    pend;
  logic [3:0]    pend_next;
  logic [3:0]    slot;
  logic          accept;
  logic          cur_in;
  logic          first_in_eff;

  assign in_ready = (pend == '0);
  assign accept   = in_valid && in_ready;
  assign cur_in   = !in_z[CW-1] && (in_z != '0);
  assign first_in_eff = awaiting ? cur_in : first_in;

  always_comb begin
    pend_next[0] = !awaiting && (prev_in != cur_in);
    pend_next[1] = cur_in;
    pend_next[2] = in_last && (cur_in != first_in_eff);
    pend_next[3] = in_last;
  end

  // lowest pending op goes first
  assign slot = pend & (~pend + 4'd1);
  assign push = (pend != '0) && !full;

  always_comb begin
    ctl.run_last = ((pend & ~slot) == '0);
    ctl.kind     = OP_DONE;
    p_x = edge_x;
    p_y = edge_y;
    p_z = edge_z;
    c_x = cur_x;
    c_y = cur_y;
    c_z = cur_z;
    case (slot)
      4'b0001: ctl.kind = OP_CROSS;
      4'b0010: ctl.kind = OP_VERTEX;
      4'b0100: begin
        ctl.kind = OP_CROSS;
        p_x = cur_x;
        p_y = cur_y;
        p_z = cur_z;
        c_x = first_x;
        c_y = first_y;
        c_z = first_z;
      end
      default: ctl.kind = OP_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      awaiting <= 1'b1;
      prev_in  <= 1'b0;
      first_in <= 1'b0;
    end else if (accept) begin
      pend     <= pend_next;
      awaiting <= in_last;
      edge_x   <= prev_x;
      edge_y   <= prev_y;
      edge_z   <= prev_z;
      prev_x   <= in_x;
      prev_y   <= in_y;
      prev_z   <= in_z;
      prev_in  <= cur_in;
      cur_x    <= in_x;
      cur_y    <= in_y;
      cur_z    <= in_z;
      if (awaiting) begin
        first_x  <= in_x;
        first_y  <= in_y;
        first_z  <= in_z;
        first_in <= cur_in;
      end
    end else if (push) begin
      pend <= pend & ~slot;
    end
  end

endmodule

[rtl/pcfp_div.sv]
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating toward zero.
module pcfp_div #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [2*CW+1:0] num,
  input  logic signed [CW:0]   den,
  output logic                 done,
  output logic signed [CW:0]   quo
);
  localparam int CNT_W = $clog2(CW + 1);

  logic [2*CW+1:0] nmag;
  logic [CW:0]     dmag_in;
  logic [CW:0]     dmag;
  logic [CW:0]     rem;
  logic [CW-1:0]   sh;
  logic            neg;
  logic            busy;
  logic [CNT_W-1:0] cnt;
  logic [CW+1:0]   trial;
  logic            qbit;

  assign nmag    = num[2*CW+1] ? -num : num;
  assign dmag_in = den[CW] ? -den : den;
  assign trial   = {rem, sh[CW-1]};
  assign qbit    = (trial >= {1'b0, dmag});
  assign quo     = neg ? -$signed({1'b0, sh}) : $signed({1'b0, sh});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(CW);
        // quotient magnitude stays below 2^CW, so the high part is already below the divisor
        rem  <= nmag[2*CW:CW];
        sh   <= nmag[CW-1:0];
        dmag <= dmag_in;
        neg  <= num[2*CW+1] ^ den[CW];
      end else if (busy) begin
        rem  <= qbit ? (CW+1)'(trial - {1'b0, dmag}) : trial[CW:0];
        sh   <= {sh[CW-2:0], qbit};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/pcfp_back.sv]
// Back part: executes clip operations, computes crossing points, counts and emits results.
module pcfp_back #(
  parameter int CW        = 16,
  parameter int COUNT_CAP = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           empty,
  output logic                           pop,
  input  pcfp_pkg::op_ctl_t              ctl,
  input  logic [CW-1:0]                  in_px,
  input  logic [CW-1:0]                  in_py,
  input  logic [CW-1:0]                  in_pz,
  input  logic [CW-1:0]                  in_cx,
  input  logic [CW-1:0]                  in_cy,
  input  logic [CW-1:0]                  in_cz,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [CW-1:0]                  out_x,
  output logic [CW-1:0]                  out_y,
  output logic [CW-1:0]                  out_z,
  output logic [pcfp_pkg::COUNT_W-1:0]   out_count,
  output logic                           out_vvalid,
  output logic                           out_cross,
  output logic                           out_done,
  output logic                           out_last
);
  import pcfp_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_EMIT} state_t;

  state_t              state;
  op_kind_t            kind;
  logic                run_last;
  logic [CW-1:0]       px, py, pz, cx, cy, cz;
  logic signed [CW:0]  diff_x, diff_y, neg_pz, dz_w;
  logic signed [2*CW+1:0] prod_x, prod_y;
  logic signed [CW:0]  dz;
  logic                div_go;
  logic                done_x, done_y;
  logic signed [CW:0]  quo_x, quo_y;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_inc;
  logic                take;

  assign pop    = (state == ST_IDLE) && !empty;
  assign take   = !out_valid || out_ready;
  assign diff_x = $signed({cx[CW-1], cx}) - $signed({px[CW-1], px});
  assign diff_y = $signed({cy[CW-1], cy}) - $signed({py[CW-1], py});
  assign neg_pz = -$signed({pz[CW-1], pz});
  assign dz_w   = $signed({cz[CW-1], cz}) - $signed({pz[CW-1], pz});
  assign count_inc = (count < COUNT_W'(COUNT_CAP)) ? count + 1'b1 : count;

  pcfp_div #(.CW(CW)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (prod_x),
    .den   (dz),
    .done  (done_x),
    .quo   (quo_x)
  );

  pcfp_div #(.CW(CW)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (prod_y),
    .den   (dz),
    .done  (done_y),
    .quo   (quo_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_go    <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      div_go <= (state == ST_MUL);
      if (state == ST_EMIT && take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            kind     <= ctl.kind;
            run_last <= ctl.run_last;
            px <= in_px;
            py <= in_py;
            pz <= in_pz;
            cx <= in_cx;
            cy <= in_cy;
            cz <= in_cz;
            state <= (ctl.kind == OP_CROSS) ? ST_MUL : ST_EMIT;
          end
        end
        ST_MUL: begin
          prod_x <= (2*CW+2)'(diff_x) * (2*CW+2)'(neg_pz);
          prod_y <= (2*CW+2)'(diff_y) * (2*CW+2)'(neg_pz);
          dz     <= dz_w;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          if (done_x && done_y) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (take) begin
            out_last  <= run_last;
            state     <= ST_IDLE;
            case (kind)
              OP_VERTEX: begin
                out_x      <= cx;
                out_y      <= cy;
                out_z      <= cz;
                out_vvalid <= 1'b1;
                out_cross  <= 1'b0;
                out_done   <= 1'b0;
                out_count  <= '0;
                count      <= count_inc;
              end
              OP_CROSS: begin
                out_x      <= px + quo_x[CW-1:0];
                out_y      <= py + quo_y[CW-1:0];
                out_z      <= '0;
                out_vvalid <= 1'b1;
                out_cross  <= 1'b1;
                out_done   <= 1'b0;
                out_count  <= '0;
                count      <= count_inc;
              end
              // OP_DONE
              default: begin
                out_x      <= '0;
                out_y      <= '0;
                out_z      <= '0;
                out_vvalid <= 1'b0;
                out_cross  <= 1'b0;
                out_done   <= 1'b1;
                out_count  <= count;
                count      <= '0;
              end
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/polygon_clip_front_plane_top.sv]
// Top level: single-plane (z > 0) polygon clipper, vertex stream in, clipped vertex stream out.
// Front accepts one vertex, then issues one queued op per cycle while the queue is not full (up to four per vertex).
// Back: a plain vertex or done marker goes from idle straight to emit; a crossing point goes through
// multiply, then the bit-serial dividers (x and y in parallel), then emit. The back pops a new op
// only from idle, and the front takes a new vertex only once all ops of the last one are queued.
// Synchronous active-high reset clears the queue, the vertex tracking and the output valid.
module polygon_clip_front_plane_top #(
  parameter int  COORD_WIDTH          = 16,
  parameter int  MAX_POLYGON_VERTICES = 64,
  localparam int IN_W  = ((3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COORD_WIDTH + pcfp_pkg::COUNT_W + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [IN_W-1:0]              s_tdata,  // vertex_x, vertex_y, vertex_z
  input  logic                         s_tlast,  // last_vertex
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [OUT_W-1:0]             m_tdata,  // out_x, out_y, out_z, out_count
  output logic [pcfp_pkg::TUSER_W-1:0] m_tuser,  // vertex_valid, is_crossing, polygon_done
  output logic                         m_tlast   // run_last
);
  import pcfp_pkg::*;

  localparam int CW        = COORD_WIDTH;
  localparam int COUNT_CAP = (2 * MAX_POLYGON_VERTICES > 255) ? 255 : 2 * MAX_POLYGON_VERTICES;
  localparam int Q_W       = $bits(op_ctl_t) + 6 * CW;

  logic          f_push, q_full, q_pop, q_empty;
  op_ctl_t       f_ctl, q_ctl;
  logic [CW-1:0] f_px, f_py, f_pz, f_cx, f_cy, f_cz;
  logic [CW-1:0] q_px, q_py, q_pz, q_cx, q_cy, q_cz;
  logic [Q_W-1:0] q_wdata, q_rdata;
  logic [CW-1:0] o_x, o_y, o_z;
  logic [COUNT_W-1:0] o_count;
  logic          o_vvalid, o_cross, o_done;

  pcfp_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_x     (s_tdata[CW-1:0]),
    .in_y     (s_tdata[2*CW-1:CW]),
    .in_z     (s_tdata[3*CW-1:2*CW]),
    .in_last  (s_tlast),
    .push     (f_push),
    .full     (q_full),
    .ctl      (f_ctl),
    .p_x      (f_px),
    .p_y      (f_py),
    .p_z      (f_pz),
    .c_x      (f_cx),
    .c_y      (f_cy),
    .c_z      (f_cz)
  );

  assign q_wdata = {f_ctl, f_px, f_py, f_pz, f_cx, f_cy, f_cz};

  pcfp_fifo #(.W(Q_W)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {q_ctl, q_px, q_py, q_pz, q_cx, q_cy, q_cz} = q_rdata;

  pcfp_back #(.CW(CW), .COUNT_CAP(COUNT_CAP)) u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (q_empty),
    .pop        (q_pop),
    .ctl        (q_ctl),
    .in_px      (q_px),
    .in_py      (q_py),
    .in_pz      (q_pz),
    .in_cx      (q_cx),
    .in_cy      (q_cy),
    .in_cz      (q_cz),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_x      (o_x),
    .out_y      (o_y),
    .out_z      (o_z),
    .out_count  (o_count),
    .out_vvalid (o_vvalid),
    .out_cross  (o_cross),
    .out_done   (o_done),
    .out_last   (m_tlast)
  );

  assign m_tdata = OUT_W'({o_count, o_z, o_y, o_x});
  assign m_tuser = {o_done, o_cross, o_vvalid};

endmodule

[rtl/pcfp_chk.sv]
// Port-level checker for the front-plane polygon clipper, bound to the top level.
module pcfp_chk #(
  parameter int  COORD_WIDTH = 16,
  localparam int OUT_W = ((3 * COORD_WIDTH + pcfp_pkg::COUNT_W + 7) / 8) * 8
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [OUT_W-1:0]             m_tdata,
  input logic [pcfp_pkg::TUSER_W-1:0] m_tuser,
  input logic                         m_tlast
);
  import pcfp_pkg::*;

  localparam int CW = COORD_WIDTH;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled item changed");

  a_done_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[TU_DONE] |-> m_tlast && !m_tuser[TU_VALID] && !m_tuser[TU_CROSS]
      && m_tdata[3*CW-1:0] == '0)
    else $error("malformed done marker");

  a_cross_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[TU_CROSS] |-> m_tuser[TU_VALID] && m_tdata[3*CW-1:2*CW] == '0)
    else $error("crossing point off the plane");

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[TU_DONE] |-> m_tdata[3*CW+COUNT_W-1:3*CW] == '0)
    else $error("count on a vertex item");

endmodule

bind polygon_clip_front_plane_top pcfp_chk #(.COORD_WIDTH(COORD_WIDTH)) u_pcfp_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
